[sv/lsq_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsq_pkg
// Shared constants, codes and types of the layered sprite queue.
// ---------------------------------------------------------------------------
package lsq_pkg;

   localparam int MAX_LAYERS    = 8;
   localparam int MAX_PER_LAYER = 8;

   localparam int LAYER_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int SLOT_W  = (MAX_PER_LAYER > 1) ? $clog2(MAX_PER_LAYER) : 1;
   localparam int FILL_W  = $clog2(MAX_PER_LAYER + 1);
   localparam int RAM_AW  = LAYER_W + SLOT_W;
   localparam int RAM_DEPTH = 1 << RAM_AW;

   // field widths of the request and response
   localparam int HANDLE_W    = 16;
   localparam int REQ_LAYER_W = 8;
   localparam int STATUS_W    = 2;
   localparam int OUT_LAYER_W = 3;

   // configuration port
   localparam int CFG_W      = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic OP_QUEUE = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_QUEUED   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DRAINED  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd3;

   localparam logic REG_LAYERS   = 1'b0;
   localparam logic REG_CAPACITY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   // effective limits, already clamped to the storage size
   typedef struct packed {
      logic [CFG_W-1:0] nlay;
      logic [CFG_W-1:0] cap;
   } cfg_type;

endpackage

[sv/lsq_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsq_if
// Request and response channel interfaces of the layered sprite queue.
// ---------------------------------------------------------------------------
interface lsq_req_if import lsq_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic                   opcode;
   logic [HANDLE_W-1:0]    sprite_handle;
   logic [REQ_LAYER_W-1:0] layer;

   modport source (output valid, opcode, sprite_handle, layer, input ready);
   modport sink   (input valid, opcode, sprite_handle, layer, output ready);
endinterface

interface lsq_rsp_if import lsq_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [HANDLE_W-1:0]    out_handle;
   logic [OUT_LAYER_W-1:0] out_layer;
   logic                   last;

   modport source (output valid, status, out_handle, out_layer, last, input ready);
   modport sink   (input valid, status, out_handle, out_layer, last, output ready);
endinterface

[sv/lsq_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module lsq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/lsq_csr.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsq_csr
// Configuration registers: layer count and per-layer capacity.
// ---------------------------------------------------------------------------
module lsq_csr import lsq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [CFG_W-1:0] layers_ff, layers_in;
   logic [CFG_W-1:0] cap_ff, cap_in;
   logic             wr_fire;
   logic             reg_sel;

   assign csr_pready = 1'b1;
   assign wr_fire    = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[CSR_ADDR_W-1];

   always_comb begin
      layers_in = layers_ff;
      cap_in    = cap_ff;
      if (wr_fire) begin
         unique case (reg_sel)
            REG_LAYERS:   layers_in = csr_pwdata[CFG_W-1:0];
            REG_CAPACITY: cap_in    = csr_pwdata[CFG_W-1:0];
            default:      layers_in = layers_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layers_ff <= CFG_W'(MAX_LAYERS);
         cap_ff    <= CFG_W'(MAX_PER_LAYER);
      end else begin
         layers_ff <= layers_in;
         cap_ff    <= cap_in;
      end
   end

   assign csr_prdata = (reg_sel == REG_CAPACITY) ?
                       {{(CSR_DATA_W-CFG_W){1'b0}}, cap_ff} :
                       {{(CSR_DATA_W-CFG_W){1'b0}}, layers_ff};

   // values above the storage size act as the storage size
   assign cfg.nlay = (layers_ff > CFG_W'(MAX_LAYERS)) ? CFG_W'(MAX_LAYERS) : layers_ff;
   assign cfg.cap  = (cap_ff > CFG_W'(MAX_PER_LAYER)) ? CFG_W'(MAX_PER_LAYER) : cap_ff;

endmodule

[sv/lsq_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsq_ctrl
// Sequencer: layer fill counters, shared fill comparator, drain walk and
// response register.
// ---------------------------------------------------------------------------
module lsq_ctrl import lsq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   lsq_req_if.sink             req,
   lsq_rsp_if.source           rsp,
   input  cfg_type             cfg,
   output logic                ram_we,
   output logic [RAM_AW-1:0]   ram_waddr,
   output logic [HANDLE_W-1:0] ram_wdata,
   output logic [RAM_AW-1:0]   ram_raddr,
   input  logic [HANDLE_W-1:0] ram_rdata
);

   state_type state_ff, state_in;
   logic [FILL_W-1:0]  fill_ff [MAX_LAYERS];
   logic [FILL_W-1:0]  fill_in [MAX_LAYERS];
   logic [LAYER_W-1:0] lay_ff, lay_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic               pend_last_ff, pend_last_in;
   logic               pend_done_ff, pend_done_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0]    rsp_handle_ff, rsp_handle_in;
   logic [OUT_LAYER_W-1:0] rsp_layer_ff, rsp_layer_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [LAYER_W-1:0]    idx;
   logic [FILL_W-1:0]     fill_sel;
   logic [FILL_W-1:0]     cmp_lhs, cmp_rhs;
   logic                  cmp_lt;
   logic [MAX_LAYERS-1:0] fill_nz;
   logic [MAX_LAYERS-1:0] above_nz;
   logic                  out_free;
   logic                  req_fire;
   logic                  queue_ok;
   logic                  slot_is_end;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire  = req.valid && req.ready;

   assign idx      = (state_ff == ST_IDLE) ? req.layer[LAYER_W-1:0] : lay_ff;
   assign fill_sel = fill_ff[idx];

   // one comparator: fill against capacity on queue, slot against fill on drain
   assign cmp_lhs = (state_ff == ST_IDLE) ? fill_sel : FILL_W'(slot_ff);
   assign cmp_rhs = (state_ff == ST_IDLE) ? FILL_W'(cfg.cap) : fill_sel;
   assign cmp_lt  = cmp_lhs < cmp_rhs;

   always_comb begin
      for (int i = 0; i < MAX_LAYERS; i++) begin
         fill_nz[i]  = fill_ff[i] != '0;
         above_nz[i] = fill_nz[i] && (LAYER_W'(i) > lay_ff);
      end
   end

   assign queue_ok = (req.sprite_handle != '0) &&
                     (REQ_LAYER_W'(cfg.nlay) > req.layer) && cmp_lt;
   assign slot_is_end = (FILL_W'(slot_ff) + FILL_W'(1)) == fill_sel;

   assign ram_raddr = {lay_ff, slot_ff};
   assign ram_waddr = {req.layer[LAYER_W-1:0], fill_sel[SLOT_W-1:0]};
   assign ram_wdata = req.sprite_handle;

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      lay_in        = lay_ff;
      slot_in       = slot_ff;
      pend_last_in  = pend_last_ff;
      pend_done_in  = pend_done_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_layer_in  = rsp_layer_ff;
      rsp_last_in   = rsp_last_ff;
      ram_we        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_valid_in  = 1'b1;
               rsp_handle_in = '0;
               rsp_layer_in  = '0;
               rsp_last_in   = 1'b1;
               if (req.opcode == OP_QUEUE) begin
                  if (queue_ok) begin
                     ram_we        = 1'b1;
                     fill_in[idx]  = fill_sel + FILL_W'(1);
                     rsp_status_in = STATUS_QUEUED;
                  end else begin
                     rsp_status_in = STATUS_REJECTED;
                  end
               end else if (fill_nz == '0) begin
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  // start the walk; no response until the first entry is read
                  rsp_valid_in = 1'b0;
                  lay_in       = '0;
                  slot_in      = '0;
                  state_in     = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (cmp_lt) begin
               pend_done_in = slot_is_end;
               pend_last_in = slot_is_end && (above_nz == '0);
               state_in     = ST_EMIT;
            end else begin
               fill_in[lay_ff] = '0;
               lay_in          = lay_ff + LAYER_W'(1);
               slot_in         = '0;
            end
         end
         ST_EMIT: begin
            // hold the read address until the entry moves into the response
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_DRAINED;
               rsp_handle_in = ram_rdata;
               rsp_layer_in  = OUT_LAYER_W'(lay_ff);
               rsp_last_in   = pend_last_ff;
               if (pend_done_ff) begin
                  fill_in[lay_ff] = '0;
                  lay_in          = lay_ff + LAYER_W'(1);
                  slot_in         = '0;
               end else begin
                  slot_in = slot_ff + SLOT_W'(1);
               end
               state_in = pend_last_ff ? ST_IDLE : ST_SCAN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         lay_ff       <= '0;
         slot_ff      <= '0;
         pend_last_ff <= 1'b0;
         pend_done_ff <= 1'b0;
         for (int i = 0; i < MAX_LAYERS; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lay_ff       <= lay_in;
         slot_ff      <= slot_in;
         pend_last_ff <= pend_last_in;
         pend_done_ff <= pend_done_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_layer_ff  <= rsp_layer_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.out_handle = rsp_handle_ff;
   assign rsp.out_layer  = rsp_layer_ff;
   assign rsp.last       = rsp_last_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_sel <= FILL_W'(MAX_PER_LAYER))
      else $error("layer fill beyond capacity");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready)
      else $error("request taken during drain");

   a_scan_has_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (fill_nz != '0))
      else $error("drain walk with nothing left to emit");

   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free && pend_last_ff) |=>
         (fill_nz == '0 && state_ff == ST_IDLE))
      else $error("layers not empty after final drained entry");

endmodule

[sv/layered_sprite_queue_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// layered_sprite_queue_unit
// Per-layer bounded queues of sprite handles, drained in depth order.
// ---------------------------------------------------------------------------
//  channel    direction  handshake          carries
//  req_chan   in         valid/ready        opcode, sprite_handle, layer
//  rsp_chan   out        valid/ready        status, out_handle, out_layer, last
//  csr_*      in         APB psel/penable   layers_in_use, capacity_in_use
//
//  A queue request is checked against the fill counters and written to the
//  handle RAM as it is accepted, one per cycle while the response register
//  drains. A drain walks the layers through the scan and emit states, paced
//  by the registered RAM read and the shared fill comparator. No request is
//  taken during a drain.
//  Reset is synchronous and empties every layer; configuration returns to 8/8.
//  A stalled response holds the sequencer in place.
// ---------------------------------------------------------------------------
module layered_sprite_queue_unit import lsq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   lsq_req_if.sink               req_chan,
   lsq_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type             cfg;
   logic                ram_we;
   logic [RAM_AW-1:0]   ram_waddr;
   logic [HANDLE_W-1:0] ram_wdata;
   logic [RAM_AW-1:0]   ram_raddr;
   logic [HANDLE_W-1:0] ram_rdata;

   lsq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lsq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .cfg       (cfg),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   lsq_ram #(
      .WIDTH (HANDLE_W),
      .DEPTH (RAM_DEPTH)
   ) u_handle_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the layered sprite queue. Sprite requests come
// from a backlog that the stimulus process fills. The bench keeps its own
// copy of the per-layer queues and predicts every response as a request is
// taken. Each response is checked in order against the prediction. Register
// settings change between phases, and idling on both channels varies.
// ---------------------------------------------------------------------------
module tb_top;
   import lsq_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_REPORTS   = 20;
   localparam logic [CSR_ADDR_W-1:0] ADDR_LAYERS   = {REG_LAYERS, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_CAPACITY = {REG_CAPACITY, 2'b00};

   typedef struct packed {
      logic                   opcode;
      logic [HANDLE_W-1:0]    handle;
      logic [REQ_LAYER_W-1:0] layer;
   } sprite_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [HANDLE_W-1:0]    handle;
      logic [OUT_LAYER_W-1:0] layer;
      logic                   last;
   } sprite_rsp_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   lsq_req_if req_bus ();
   lsq_rsp_if rsp_bus ();

   layered_sprite_queue_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // bench copy of the display list
   logic [CFG_W-1:0]    layers_cfg;
   logic [CFG_W-1:0]    capacity_cfg;
   logic [FILL_W-1:0]   held_count [MAX_LAYERS];
   logic [HANDLE_W-1:0] held_handles [MAX_LAYERS*MAX_PER_LAYER];

   sprite_req_type request_backlog [$];
   sprite_rsp_type awaited_rsp [$];

   int send_idle_pct;
   int rsp_stall_pct;
   int error_count;
   int queue_reqs;
   int drain_reqs;
   int rsp_checked;
   int settings_used;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("%0t: timed out with %0d requests and %0d responses outstanding",
               $realtime, request_backlog.size(), awaited_rsp.size());
      $display("FAILURE");
      $finish;
   end

   function automatic sprite_req_type mk_req(input logic op,
                                             input logic [HANDLE_W-1:0] h,
                                             input logic [REQ_LAYER_W-1:0] l);
      sprite_req_type r;
      r.opcode = op;
      r.handle = h;
      r.layer  = l;
      return r;
   endfunction

   // update the display list and queue the responses the request must give
   function automatic void apply_request(input sprite_req_type r);
      int             span;
      int             cap;
      int             total;
      int             n;
      sprite_rsp_type rsp;
      span = (layers_cfg > MAX_LAYERS) ? MAX_LAYERS : int'(layers_cfg);
      cap  = (capacity_cfg > MAX_PER_LAYER) ? MAX_PER_LAYER : int'(capacity_cfg);
      rsp  = '0;
      if (r.opcode == OP_QUEUE) begin
         queue_reqs++;
         rsp.last = 1'b1;
         if (r.handle == '0 || r.layer >= span || held_count[r.layer] >= cap) begin
            rsp.status = STATUS_REJECTED;
         end else begin
            held_handles[r.layer*MAX_PER_LAYER + held_count[r.layer]] = r.handle;
            held_count[r.layer]++;
            rsp.status = STATUS_QUEUED;
         end
         awaited_rsp.push_back(rsp);
      end else begin
         drain_reqs++;
         total = 0;
         foreach (held_count[i]) total += held_count[i];
         n = 0;
         for (int i = 0; i < MAX_LAYERS; i++) begin
            for (int a = 0; a < held_count[i]; a++) begin
               n++;
               rsp.status = STATUS_DRAINED;
               rsp.handle = held_handles[i*MAX_PER_LAYER + a];
               rsp.layer  = OUT_LAYER_W'(i);
               rsp.last   = (n == total);
               awaited_rsp.push_back(rsp);
            end
            held_count[i] = '0;
         end
         if (total == 0) begin
            rsp.status = STATUS_EMPTY;
            rsp.last   = 1'b1;
            awaited_rsp.push_back(rsp);
         end
      end
   endfunction

   // mostly well-formed queue requests into live layers, with drains and junk mixed in
   function automatic sprite_req_type make_request();
      int             roll;
      int             span;
      sprite_req_type r;
      roll = $urandom_range(99);
      span = (layers_cfg > MAX_LAYERS) ? MAX_LAYERS : int'(layers_cfg);
      r.opcode = OP_QUEUE;
      r.handle = HANDLE_W'($urandom_range(65535, 1));
      r.layer  = (span == 0) ? REQ_LAYER_W'($urandom_range(MAX_LAYERS-1))
                             : REQ_LAYER_W'($urandom_range(span-1));
      if (roll < 10) begin
         r.opcode = OP_DRAIN;
         r.handle = HANDLE_W'($urandom);
         r.layer  = REQ_LAYER_W'($urandom);
      end else if (roll < 16) begin
         r.handle = '0;
      end else if (roll < 22) begin
         r.layer = REQ_LAYER_W'($urandom_range(255));
      end
      return r;
   endfunction

   task automatic settle();
      while (request_backlog.size() != 0 || awaited_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_LAYERS) layers_cfg = value[CFG_W-1:0];
      else capacity_cfg = value[CFG_W-1:0];
   endtask

   task automatic set_limits(input logic [CSR_DATA_W-1:0] layers,
                             input logic [CSR_DATA_W-1:0] capacity);
      settle();
      write_reg(ADDR_LAYERS, layers);
      write_reg(ADDR_CAPACITY, capacity);
      settings_used++;
   endtask

   task automatic run_phase(input logic [CSR_DATA_W-1:0] layers,
                            input logic [CSR_DATA_W-1:0] capacity,
                            input int idle_pct, input int stall_pct, input int count);
      set_limits(layers, capacity);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) request_backlog.push_back(make_request());
   endtask

   // request driver: hold the request until taken, then predict its responses
   always @(posedge clock) begin : req_driver
      sprite_req_type sent;
      if (reset) begin
         req_bus.valid         <= 1'b0;
         req_bus.opcode        <= OP_QUEUE;
         req_bus.sprite_handle <= '0;
         req_bus.layer         <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            sent = request_backlog.pop_front();
            apply_request(sent);
         end
         if (!(req_bus.valid && !req_bus.ready)) begin
            if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_bus.valid         <= 1'b1;
               req_bus.opcode        <= request_backlog[0].opcode;
               req_bus.sprite_handle <= request_backlog[0].handle;
               req_bus.layer         <= request_backlog[0].layer;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      sprite_rsp_type got;
      sprite_rsp_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.status, rsp_bus.out_handle, rsp_bus.out_layer, rsp_bus.last};
            rsp_checked++;
            if (awaited_rsp.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display({"%0t: unexpected response, expected none, ",
                            "got status %0d handle %h layer %0d last %0d"},
                           $realtime, got.status, got.handle, got.layer, got.last);
            end else begin
               want = awaited_rsp.pop_front();
               if (got !== want) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display({"%0t: mismatch, expected status %0d handle %h layer %0d ",
                               "last %0d, got status %0d handle %h layer %0d last %0d"},
                              $realtime, want.status, want.handle, want.layer, want.last,
                              got.status, got.handle, got.layer, got.last);
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin : stimulus
      reset                 <= 1'b1;
      csr_psel              <= 1'b0;
      csr_penable           <= 1'b0;
      csr_pwrite            <= 1'b0;
      csr_paddr             <= '0;
      csr_pwdata            <= '0;
      layers_cfg    = CFG_W'(MAX_LAYERS);
      capacity_cfg  = CFG_W'(MAX_PER_LAYER);
      foreach (held_count[i]) held_count[i] = '0;
      foreach (held_handles[i]) held_handles[i] = '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      error_count   = 0;
      queue_reqs    = 0;
      drain_reqs    = 0;
      rsp_checked   = 0;
      settings_used = 1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty drain, null handle, out-of-range layers, a full layer
      request_backlog.push_back(mk_req(OP_DRAIN, 16'h0000, 8'h00));
      request_backlog.push_back(mk_req(OP_QUEUE, 16'h0000, 8'h00));
      request_backlog.push_back(mk_req(OP_QUEUE, 16'hFFFF, 8'h07));
      request_backlog.push_back(mk_req(OP_QUEUE, 16'h0001, 8'h00));
      request_backlog.push_back(mk_req(OP_QUEUE, 16'hA5A5, 8'h08));
      request_backlog.push_back(mk_req(OP_QUEUE, 16'h5A5A, 8'hFF));
      for (int k = 0; k <= MAX_PER_LAYER; k++)
         request_backlog.push_back(mk_req(OP_QUEUE, HANDLE_W'(16'h1000 + k), 8'h03));
      request_backlog.push_back(mk_req(OP_DRAIN, 16'hFFFF, 8'hFF));
      request_backlog.push_back(mk_req(OP_DRAIN, 16'h0000, 8'h00));
      for (int k = 0; k < 3; k++)
         request_backlog.push_back(mk_req(OP_QUEUE, HANDLE_W'(16'h6000 + k), 8'h06));
      for (int k = 0; k < 2; k++)
         request_backlog.push_back(mk_req(OP_QUEUE, HANDLE_W'(16'h0100 + k), 8'h01));

      // shrink the limits to zero while entries are held: drain must still empty all
      set_limits(0, 0);
      request_backlog.push_back(mk_req(OP_QUEUE, 16'h7777, 8'h00));
      request_backlog.push_back(mk_req(OP_DRAIN, 16'h0000, 8'h00));

      run_phase(8, 8, 0, 0, 60);
      run_phase(4, 3, 55, 0, 60);
      run_phase(1, 1, 0, 55, 60);
      run_phase(32'hFFFF_FFFF, 32'h0000_001F, 34, 34, 60);
      run_phase(0, 5, 0, 0, 30);
      run_phase(6, 0, 34, 34, 30);
      run_phase(3, 8, 55, 55, 60);

      // fill every layer to capacity, send two more past it, and drain the lot
      run_phase(8, 8, 0, 0, 0);
      for (int k = 0; k < MAX_LAYERS*MAX_PER_LAYER + 2; k++)
         request_backlog.push_back(mk_req(OP_QUEUE, HANDLE_W'($urandom_range(65535, 1)),
                                          REQ_LAYER_W'(k % MAX_LAYERS)));
      request_backlog.push_back(mk_req(OP_DRAIN, 16'h0000, 8'h00));
      // wait until every response is back before queueing more requests
      settle();
      repeat (30) request_backlog.push_back(make_request());

      settle();
      $display("Checked %0d responses to %0d queue and %0d drain requests", rsp_checked,
               queue_reqs, drain_reqs);
      $display("across %0d register settings with varied idling and back-pressure",
               settings_used);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[layered_sprite_queue_unit.f]
sv/lsq_pkg.sv
sv/lsq_if.sv
sv/lsq_ram.sv
sv/lsq_csr.sv
sv/lsq_ctrl.sv
sv/layered_sprite_queue_unit.sv
sim/tb_top.sv
